@@ rtl/core/asrelax_pkg.sv @@
// ----------------------------------------------------------------------------
// asrelax_pkg
// Shared types and constants of the A* open set relax engine.
// ----------------------------------------------------------------------------
package asrelax_pkg;

   localparam int VTX_BITS   = 12;
   localparam int VID_BITS   = 13;
   localparam int EDGE_BITS  = 16;
   localparam int COST_BITS  = 24;
   localparam int FRAC_BITS  = 8;
   localparam int BEST_BITS  = 32;
   localparam int KEY_BITS   = COST_BITS + FRAC_BITS + 1;
   localparam int ENTRY_BITS = KEY_BITS + VTX_BITS;
   localparam int DIV_BITS   = 12;
   localparam int DSR_BITS   = 13;
   localparam int RAD_BITS   = 32;
   localparam int ROOT_BITS  = 24;
   localparam int MAX_VERTICES = 4096;

   localparam logic [VID_BITS-1:0]  NONE_VTX = 13'd4096;
   localparam logic [COST_BITS-1:0] COST_INF = '1;
   localparam logic [BEST_BITS-1:0] BEST_INF = '1;

   localparam logic [2:0] REQ_EDGE   = 3'd0;
   localparam logic [2:0] REQ_OFFER  = 3'd1;
   localparam logic [2:0] REQ_EXPAND = 3'd2;
   localparam logic [2:0] REQ_END    = 3'd3;
   localparam logic [2:0] REQ_PRED   = 3'd4;

   localparam logic [2:0] OUT_IGNORED  = 3'd0;
   localparam logic [2:0] OUT_ACCEPTED = 3'd1;
   localparam logic [2:0] OUT_FORWARD  = 3'd2;
   localparam logic [2:0] OUT_EXPANDED = 3'd3;
   localparam logic [2:0] OUT_GOAL     = 3'd4;
   localparam logic [2:0] OUT_EMPTY    = 3'd5;
   localparam logic [2:0] OUT_PRED     = 3'd6;
   localparam logic [2:0] OUT_FULL     = 3'd7;

   localparam logic [1:0] REG_PART_ID    = 2'd0;
   localparam logic [1:0] REG_PART_COUNT = 2'd1;
   localparam logic [1:0] REG_GOAL       = 2'd2;
   localparam logic [1:0] REG_COLUMNS    = 2'd3;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DSR_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
      logic [DIV_BITS-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                start;
      logic [RAD_BITS-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] root;
   } sqrt_rsp_type;

endpackage

@@ rtl/core/asrelax_ram.sv @@
// ----------------------------------------------------------------------------
// asrelax_ram
// Simple dual port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module asrelax_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/asrelax_div.sv @@
// ----------------------------------------------------------------------------
// asrelax_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asrelax_div (
   input  logic                     clock,
   input  logic                     reset,
   input  asrelax_pkg::div_req_type req,
   output asrelax_pkg::div_rsp_type rsp
);

   localparam int NB = asrelax_pkg::DIV_BITS;
   localparam int DB = asrelax_pkg::DSR_BITS;
   localparam int CB = $clog2(NB + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [NB-1:0] num_ff, num_in;
   logic [DB-1:0] rem_ff, rem_in;
   logic [DB-1:0] dsr_ff, dsr_in;
   logic [DB:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff, num_ff[NB-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CB'(NB);
         num_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = DB'(rem_sh - {1'b0, dsr_ff});
            num_in = {num_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DB-1:0];
            num_in = {num_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = num_ff;
   assign rsp.remainder = rem_ff[NB-1:0];

endmodule

@@ rtl/core/asrelax_sqrt.sv @@
// ----------------------------------------------------------------------------
// asrelax_sqrt
// Bit-pair square root of radicand * 2^(2*FRAC_BITS), one root bit per cycle.
// ----------------------------------------------------------------------------
module asrelax_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  asrelax_pkg::sqrt_req_type req,
   output asrelax_pkg::sqrt_rsp_type rsp
);

   localparam int RB = asrelax_pkg::RAD_BITS;
   localparam int QB = asrelax_pkg::ROOT_BITS;
   localparam int CB = $clog2(QB + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [RB-1:0] rad_ff, rad_in;
   logic [QB:0]   rem_ff, rem_in;
   logic [QB-1:0] root_ff, root_in;
   logic [QB+2:0] rem_sh;
   logic [QB+2:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, rad_ff[RB-1:RB-2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CB'(QB);
         rad_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RB-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (QB+1)'(rem_sh - trial);
            root_in = {root_ff[QB-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[QB:0];
            root_in = {root_ff[QB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

@@ rtl/core/astar_open_set_relax_engine_unit.sv @@
// ----------------------------------------------------------------------------
// astar_open_set_relax_engine_unit
// One partition of a partitioned grid A* search: cost and predecessor tables
// and a min-heap open set keyed by f = (g + 10 * euclidean distance) * 2^8.
//
// Usage: present an item on the req_ ports with start high; it is taken at a
// rising edge where busy is low. busy stays high until the single result has
// been shown: rsp_valid is high for one cycle with the rsp_ fields and the
// receiver must take it then. The user must write registers over the
// APB-style port only while busy is low and no item is in flight; the block
// itself does not enforce this.
// Work per item: a forward takes one division; a local relax with push climbs
// the heap after a heuristic of two 12-step divisions and a 24-step square
// root; an expand descends the heap. One item is processed at a time.
// Reset: a clearing pass sets every cost to infinity and every predecessor to
// none, with busy high throughout; register writes are taken.
// ----------------------------------------------------------------------------
module astar_open_set_relax_engine_unit #(
   parameter int HEAP_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [11:0] req_vertex,
   input  logic [12:0] req_from_vertex,
   input  logic [15:0] req_edge_cost,
   input  logic [23:0] req_path_cost,
   output logic        rsp_valid,
   output logic [2:0]  rsp_outcome,
   output logic [12:0] rsp_out_vertex,
   output logic [12:0] rsp_out_from,
   output logic [23:0] rsp_out_cost,
   output logic [7:0]  rsp_out_partition,
   output logic        rsp_open_cleared,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int VB = asrelax_pkg::VTX_BITS;
   localparam int FB = asrelax_pkg::VID_BITS;
   localparam int CB = asrelax_pkg::COST_BITS;
   localparam int KB = asrelax_pkg::KEY_BITS;
   localparam int EB = asrelax_pkg::ENTRY_BITS;
   localparam int IW = $clog2(HEAP_DEPTH);
   localparam int NW = $clog2(HEAP_DEPTH + 1);
   localparam logic [NW-1:0] HEAP_FULL = NW'(HEAP_DEPTH);

   localparam logic [4:0] ST_CLEAR    = 5'd0;
   localparam logic [4:0] ST_IDLE     = 5'd1;
   localparam logic [4:0] ST_DONE     = 5'd2;
   localparam logic [4:0] ST_NB_RD    = 5'd3;
   localparam logic [4:0] ST_NB_DIV   = 5'd4;
   localparam logic [4:0] ST_RX_ISSUE = 5'd5;
   localparam logic [4:0] ST_RX_CMP   = 5'd6;
   localparam logic [4:0] ST_H_DIVV   = 5'd7;
   localparam logic [4:0] ST_H_DIVG   = 5'd8;
   localparam logic [4:0] ST_H_SQ1    = 5'd9;
   localparam logic [4:0] ST_H_SQ2    = 5'd10;
   localparam logic [4:0] ST_H_SCALE  = 5'd11;
   localparam logic [4:0] ST_H_SQRT   = 5'd12;
   localparam logic [4:0] ST_PU_CHK   = 5'd13;
   localparam logic [4:0] ST_PU_CMP   = 5'd14;
   localparam logic [4:0] ST_POP_TOP  = 5'd15;
   localparam logic [4:0] ST_POP_LAST = 5'd16;
   localparam logic [4:0] ST_SD_L     = 5'd17;
   localparam logic [4:0] ST_SD_R     = 5'd18;
   localparam logic [4:0] ST_SD_CMP   = 5'd19;
   localparam logic [4:0] ST_SD_MOV   = 5'd20;
   localparam logic [4:0] ST_POP_END  = 5'd21;
   localparam logic [4:0] ST_POP_COST = 5'd22;
   localparam logic [4:0] ST_PRED     = 5'd23;

   logic [4:0]    state_ff, state_in;
   logic [VB-1:0] clr_ff, clr_in;
   logic [NW-1:0] count_ff, count_in;
   logic [31:0]   best_ff, best_in;
   logic [7:0]    pid_ff, pid_in;
   logic [8:0]    pcnt_ff, pcnt_in;
   logic [VB-1:0] goal_ff, goal_in;
   logic [12:0]   cols_ff, cols_in;

   logic [VB-1:0] v_ff, v_in;
   logic [FB-1:0] from_ff, from_in;
   logic [15:0]   edge_ff, edge_in;
   logic [CB-1:0] g_ff, g_in;
   logic [2:0]    out_outcome_ff, out_outcome_in;
   logic [FB-1:0] out_vertex_ff, out_vertex_in;
   logic [FB-1:0] out_from_ff, out_from_in;
   logic [CB-1:0] out_cost_ff, out_cost_in;
   logic [7:0]    out_part_ff, out_part_in;
   logic          out_cleared_ff, out_cleared_in;
   logic [VB-1:0] vr_ff, vr_in;
   logic [VB-1:0] vc_ff, vc_in;
   logic [VB-1:0] dr_ff, dr_in;
   logic [VB-1:0] dc_ff, dc_in;
   logic [23:0]   sq_ff, sq_in;
   logic [24:0]   sum_ff, sum_in;
   logic [EB-1:0] entry_ff, entry_in;
   logic [EB-1:0] top_ff, top_in;
   logic [EB-1:0] last_ff, last_in;
   logic [EB-1:0] cand_ff, cand_in;
   logic [IW-1:0] hole_ff, hole_in;
   logic [IW-1:0] mi_ff, mi_in;
   logic          mhole_ff, mhole_in;
   logic [IW:0]   l_ff, l_in;

   logic          tab_wr_en;
   logic [VB-1:0] tab_wr_addr;
   logic [CB-1:0] cost_wr_data;
   logic [FB-1:0] pred_wr_data;
   logic [VB-1:0] cost_rd_addr;
   logic [VB-1:0] pred_rd_addr;
   logic [CB-1:0] cost_rd_data;
   logic [FB-1:0] pred_rd_data;
   logic          heap_wr_en;
   logic [IW-1:0] heap_wr_addr;
   logic [EB-1:0] heap_wr_data;
   logic [IW-1:0] heap_rd_addr;
   logic [EB-1:0] heap_rd_data;

   asrelax_pkg::div_req_type  div_req;
   asrelax_pkg::div_rsp_type  div_rsp;
   asrelax_pkg::sqrt_req_type sqrt_req;
   asrelax_pkg::sqrt_rsp_type sqrt_rsp;

   logic [8:0]    cnt_eff;
   logic [12:0]   cols_eff;
   logic [CB:0]   g_sum;
   logic [IW:0]   count_wide;
   logic [IW:0]   r_idx;
   logic [39:0]   best_scaled;
   logic          wr_hit;

   asrelax_ram #(.WIDTH(CB), .DEPTH(asrelax_pkg::MAX_VERTICES)) u_cost_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (cost_wr_data),
      .rd_addr (cost_rd_addr),
      .rd_data (cost_rd_data)
   );

   asrelax_ram #(.WIDTH(FB), .DEPTH(asrelax_pkg::MAX_VERTICES)) u_pred_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (pred_wr_data),
      .rd_addr (pred_rd_addr),
      .rd_data (pred_rd_data)
   );

   asrelax_ram #(.WIDTH(EB), .DEPTH(HEAP_DEPTH)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_wr_en),
      .wr_addr (heap_wr_addr),
      .wr_data (heap_wr_data),
      .rd_addr (heap_rd_addr),
      .rd_data (heap_rd_data)
   );

   asrelax_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   asrelax_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   assign cnt_eff = (pcnt_ff == 9'd0) ? 9'd1 : ((pcnt_ff > 9'h100) ? 9'h100 : pcnt_ff);
   assign cols_eff = (cols_ff == 13'd0) ? 13'd1 : cols_ff;
   assign g_sum = {1'b0, cost_rd_data} + (CB+1)'(edge_ff);
   assign count_wide = (IW+1)'(count_ff);
   assign r_idx = l_ff + 1'b1;
   assign best_scaled = {best_ff, 8'h00};
   assign wr_hit = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3:2])
         asrelax_pkg::REG_PART_ID:    prdata = {24'd0, pid_ff};
         asrelax_pkg::REG_PART_COUNT: prdata = {23'd0, pcnt_ff};
         asrelax_pkg::REG_GOAL:       prdata = {20'd0, goal_ff};
         asrelax_pkg::REG_COLUMNS:    prdata = {19'd0, cols_ff};
         default:                     prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      count_in       = count_ff;
      best_in        = best_ff;
      pid_in         = pid_ff;
      pcnt_in        = pcnt_ff;
      goal_in        = goal_ff;
      cols_in        = cols_ff;
      v_in           = v_ff;
      from_in        = from_ff;
      edge_in        = edge_ff;
      g_in           = g_ff;
      out_outcome_in = out_outcome_ff;
      out_vertex_in  = out_vertex_ff;
      out_from_in    = out_from_ff;
      out_cost_in    = out_cost_ff;
      out_part_in    = out_part_ff;
      out_cleared_in = out_cleared_ff;
      vr_in          = vr_ff;
      vc_in          = vc_ff;
      dr_in          = dr_ff;
      dc_in          = dc_ff;
      sq_in          = sq_ff;
      sum_in         = sum_ff;
      entry_in       = entry_ff;
      top_in         = top_ff;
      last_in        = last_ff;
      cand_in        = cand_ff;
      hole_in        = hole_ff;
      mi_in          = mi_ff;
      mhole_in       = mhole_ff;
      l_in           = l_ff;

      tab_wr_en      = 1'b0;
      tab_wr_addr    = v_ff;
      cost_wr_data   = g_ff;
      pred_wr_data   = from_ff;
      cost_rd_addr   = v_ff;
      pred_rd_addr   = v_ff;
      heap_wr_en     = 1'b0;
      heap_wr_addr   = hole_ff;
      heap_wr_data   = entry_ff;
      heap_rd_addr   = '0;
      div_req        = '0;
      sqrt_req       = '0;

      if (wr_hit) begin
         unique case (paddr[3:2])
            asrelax_pkg::REG_PART_ID:    pid_in  = pwdata[7:0];
            asrelax_pkg::REG_PART_COUNT: pcnt_in = pwdata[8:0];
            asrelax_pkg::REG_GOAL:       goal_in = pwdata[11:0];
            asrelax_pkg::REG_COLUMNS:    cols_in = pwdata[12:0];
            default:                     pid_in  = pid_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            tab_wr_en    = 1'b1;
            tab_wr_addr  = clr_ff;
            cost_wr_data = asrelax_pkg::COST_INF;
            pred_wr_data = asrelax_pkg::NONE_VTX;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cost_rd_addr = req_from_vertex[VB-1:0];
            pred_rd_addr = (req_type == asrelax_pkg::REQ_EDGE) ?
                           req_from_vertex[VB-1:0] : req_vertex;
            if (start) begin
               v_in           = req_vertex;
               from_in        = req_from_vertex;
               edge_in        = req_edge_cost;
               g_in           = req_path_cost;
               out_outcome_in = asrelax_pkg::OUT_IGNORED;
               out_vertex_in  = '0;
               out_from_in    = asrelax_pkg::NONE_VTX;
               out_cost_in    = '0;
               out_part_in    = '0;
               out_cleared_in = 1'b0;
               case (req_type)
                  asrelax_pkg::REQ_EDGE: begin
                     state_in = req_from_vertex[VB] ? ST_DONE : ST_NB_RD;
                  end
                  asrelax_pkg::REQ_OFFER: begin
                     state_in = ST_RX_ISSUE;
                  end
                  asrelax_pkg::REQ_EXPAND: begin
                     if (count_ff == '0) begin
                        out_outcome_in = asrelax_pkg::OUT_EMPTY;
                        state_in       = ST_DONE;
                     end else begin
                        state_in = ST_POP_TOP;
                     end
                  end
                  asrelax_pkg::REQ_END: begin
                     best_in        = {8'd0, req_path_cost};
                     out_outcome_in = asrelax_pkg::OUT_ACCEPTED;
                     out_cost_in    = req_path_cost;
                     state_in       = ST_DONE;
                  end
                  asrelax_pkg::REQ_PRED: begin
                     state_in = ST_PRED;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         ST_PRED: begin
            out_outcome_in = asrelax_pkg::OUT_PRED;
            out_vertex_in  = pred_rd_data;
            state_in       = ST_DONE;
         end
         ST_NB_RD: begin
            if (pred_rd_data == {1'b0, v_ff}) begin
               state_in = ST_DONE;
            end else begin
               g_in             = g_sum[CB] ? asrelax_pkg::COST_INF : g_sum[CB-1:0];
               div_req.start    = 1'b1;
               div_req.dividend = v_ff;
               div_req.divisor  = {4'd0, cnt_eff};
               state_in         = ST_NB_DIV;
            end
         end
         ST_NB_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder[7:0] == pid_ff) begin
                  state_in = ST_RX_ISSUE;
               end else begin
                  out_outcome_in = asrelax_pkg::OUT_FORWARD;
                  out_vertex_in  = {1'b0, v_ff};
                  out_from_in    = from_ff;
                  out_cost_in    = g_ff;
                  out_part_in    = div_rsp.remainder[7:0];
                  state_in       = ST_DONE;
               end
            end
         end
         ST_RX_ISSUE: begin
            state_in = ST_RX_CMP;
         end
         ST_RX_CMP: begin
            if (g_ff >= cost_rd_data) begin
               state_in = ST_DONE;
            end else begin
               tab_wr_en     = 1'b1;
               out_vertex_in = {1'b0, v_ff};
               out_from_in   = from_ff;
               out_cost_in   = g_ff;
               if (count_ff >= HEAP_FULL) begin
                  out_outcome_in = asrelax_pkg::OUT_FULL;
                  state_in       = ST_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = v_ff;
                  div_req.divisor  = cols_eff;
                  state_in         = ST_H_DIVV;
               end
            end
         end
         ST_H_DIVV: begin
            if (div_rsp.done) begin
               vr_in            = div_rsp.quotient;
               vc_in            = div_rsp.remainder;
               div_req.start    = 1'b1;
               div_req.dividend = goal_ff;
               div_req.divisor  = cols_eff;
               state_in         = ST_H_DIVG;
            end
         end
         ST_H_DIVG: begin
            if (div_rsp.done) begin
               dr_in = (vr_ff > div_rsp.quotient) ? vr_ff - div_rsp.quotient
                                                  : div_rsp.quotient - vr_ff;
               dc_in = (vc_ff > div_rsp.remainder) ? vc_ff - div_rsp.remainder
                                                   : div_rsp.remainder - vc_ff;
               state_in = ST_H_SQ1;
            end
         end
         ST_H_SQ1: begin
            sq_in    = dr_ff * dr_ff;
            state_in = ST_H_SQ2;
         end
         ST_H_SQ2: begin
            sum_in   = {1'b0, sq_ff} + 25'(dc_ff * dc_ff);
            state_in = ST_H_SCALE;
         end
         ST_H_SCALE: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = (32'(sum_ff) << 6) + (32'(sum_ff) << 5) + (32'(sum_ff) << 2);
            state_in          = ST_H_SQRT;
         end
         ST_H_SQRT: begin
            if (sqrt_rsp.done) begin
               entry_in = {KB'({g_ff, 8'h00}) + KB'(sqrt_rsp.root), v_ff};
               hole_in  = count_ff[IW-1:0];
               state_in = ST_PU_CHK;
            end
         end
         ST_PU_CHK: begin
            heap_rd_addr = IW'((hole_ff - 1'b1) >> 1);
            if (hole_ff == '0) begin
               heap_wr_en     = 1'b1;
               count_in       = count_ff + 1'b1;
               out_outcome_in = asrelax_pkg::OUT_ACCEPTED;
               state_in       = ST_DONE;
            end else begin
               state_in = ST_PU_CMP;
            end
         end
         ST_PU_CMP: begin
            heap_wr_en = 1'b1;
            if (entry_ff < heap_rd_data) begin
               heap_wr_data = heap_rd_data;
               hole_in      = IW'((hole_ff - 1'b1) >> 1);
               state_in     = ST_PU_CHK;
            end else begin
               count_in       = count_ff + 1'b1;
               out_outcome_in = asrelax_pkg::OUT_ACCEPTED;
               state_in       = ST_DONE;
            end
         end
         ST_POP_TOP: begin
            top_in       = heap_rd_data;
            count_in     = count_ff - 1'b1;
            heap_rd_addr = IW'(count_ff - 1'b1);
            state_in     = ST_POP_LAST;
         end
         ST_POP_LAST: begin
            last_in  = heap_rd_data;
            hole_in  = '0;
            state_in = ST_SD_L;
         end
         ST_SD_L: begin
            l_in         = {hole_ff, 1'b1};
            heap_rd_addr = hole_ff[IW-2:0] << 1 | IW'(1);
            if ({hole_ff, 1'b1} >= count_wide) begin
               heap_wr_en   = 1'b1;
               heap_wr_data = last_ff;
               state_in     = ST_POP_END;
            end else begin
               state_in = ST_SD_R;
            end
         end
         ST_SD_R: begin
            heap_rd_addr = r_idx[IW-1:0];
            if (heap_rd_data < last_ff) begin
               cand_in  = heap_rd_data;
               mi_in    = l_ff[IW-1:0];
               mhole_in = 1'b0;
            end else begin
               cand_in  = last_ff;
               mi_in    = hole_ff;
               mhole_in = 1'b1;
            end
            state_in = (r_idx < count_wide) ? ST_SD_CMP : ST_SD_MOV;
         end
         ST_SD_CMP: begin
            if (heap_rd_data < cand_ff) begin
               cand_in  = heap_rd_data;
               mi_in    = r_idx[IW-1:0];
               mhole_in = 1'b0;
            end
            state_in = ST_SD_MOV;
         end
         ST_SD_MOV: begin
            heap_wr_en = 1'b1;
            if (mhole_ff) begin
               heap_wr_data = last_ff;
               state_in     = ST_POP_END;
            end else begin
               heap_wr_data = cand_ff;
               hole_in      = mi_ff;
               state_in     = ST_SD_L;
            end
         end
         ST_POP_END: begin
            cost_rd_addr = top_ff[VB-1:0];
            if (best_ff != asrelax_pkg::BEST_INF &&
                40'(top_ff[EB-1:VB]) > best_scaled) begin
               count_in       = '0;
               out_cleared_in = 1'b1;
            end
            state_in = ST_POP_COST;
         end
         ST_POP_COST: begin
            out_vertex_in = {1'b0, top_ff[VB-1:0]};
            out_cost_in   = cost_rd_data;
            if (top_ff[VB-1:0] == goal_ff) begin
               best_in = (cost_rd_data == asrelax_pkg::COST_INF) ?
                         asrelax_pkg::BEST_INF : {8'd0, cost_rd_data};
               out_outcome_in = asrelax_pkg::OUT_GOAL;
            end else begin
               out_outcome_in = asrelax_pkg::OUT_EXPANDED;
            end
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
         best_ff  <= asrelax_pkg::BEST_INF;
         pid_ff   <= 8'd0;
         pcnt_ff  <= 9'd1;
         goal_ff  <= '0;
         cols_ff  <= 13'd64;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         best_ff  <= best_in;
         pid_ff   <= pid_in;
         pcnt_ff  <= pcnt_in;
         goal_ff  <= goal_in;
         cols_ff  <= cols_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff           <= v_in;
      from_ff        <= from_in;
      edge_ff        <= edge_in;
      g_ff           <= g_in;
      out_outcome_ff <= out_outcome_in;
      out_vertex_ff  <= out_vertex_in;
      out_from_ff    <= out_from_in;
      out_cost_ff    <= out_cost_in;
      out_part_ff    <= out_part_in;
      out_cleared_ff <= out_cleared_in;
      vr_ff          <= vr_in;
      vc_ff          <= vc_in;
      dr_ff          <= dr_in;
      dc_ff          <= dc_in;
      sq_ff          <= sq_in;
      sum_ff         <= sum_in;
      entry_ff       <= entry_in;
      top_ff         <= top_in;
      last_ff        <= last_in;
      cand_ff        <= cand_in;
      hole_ff        <= hole_in;
      mi_ff          <= mi_in;
      mhole_ff       <= mhole_in;
      l_ff           <= l_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_outcome       = out_outcome_ff;
   assign rsp_out_vertex    = out_vertex_ff;
   assign rsp_out_from      = out_from_ff;
   assign rsp_out_cost      = out_cost_ff;
   assign rsp_out_partition = out_part_ff;
   assign rsp_open_cleared  = out_cleared_ff;

endmodule

@@ rtl/core/asrelax_checker.sv @@
// ----------------------------------------------------------------------------
// asrelax_checker
// Port-level checks of the relax engine, bound to the top level.
// ----------------------------------------------------------------------------
module asrelax_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_outcome,
   input logic [12:0] rsp_out_vertex,
   input logic        rsp_open_cleared
);

   assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("transfer taken but busy not raised");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy ##1 !rsp_valid)
      else $error("result strobe not a single busy cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_open_cleared |->
         (rsp_outcome == asrelax_pkg::OUT_EXPANDED || rsp_outcome == asrelax_pkg::OUT_GOAL))
      else $error("open set cleared outside an expand");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == asrelax_pkg::OUT_EMPTY |->
         rsp_out_vertex == 13'd0 && !rsp_open_cleared)
      else $error("empty result carries data");

endmodule

bind astar_open_set_relax_engine_unit asrelax_checker u_checker (.*);
